FILE: sv/arpc_pkg.sv
// Shared types, widths and constants for the ARP cache with entry aging.
package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int ACT_W      = 2;
    localparam int IFACE_W    = 8;
    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int LIFE_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ENTRY_W    = IFACE_W + IP_W + MAC_W;

    localparam logic [IP_W-1:0]    BCAST_IP         = 32'hFFFF_FFFF;
    localparam logic [IFACE_W-1:0] BCAST_IFACE      = 8'hFF;
    localparam logic [MAC_W-1:0]   BCAST_MAC        = 48'hFFFF_FFFF_FFFF;
    localparam logic [LIFE_W-1:0]  DEFAULT_LIFETIME = 10'd1000;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT    = 2'd0,
        ACT_QUERY_IP  = 2'd1,
        ACT_QUERY_MAC = 2'd2,
        ACT_TICK      = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BCAST_ADDR  = 3'd0,
        CFG_SUBNET_ADDR = 3'd1,
        CFG_SUBNET_MASK = 3'd2,
        CFG_DEF_ROUTER  = 3'd3,
        CFG_LIFETIME    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    bcast;
        logic    scan_done;
        logic    out_free;
    } t_stat;

endpackage

FILE: sv/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/arpc_ctrl.sv
// Sequencer for the ARP cache: accept, table scan, insert write, result hand-off.
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // broadcast queries are answered without touching the table
                if (i_stat.action == ACT_QUERY_IP && i_stat.bcast) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.scan_done) begin
                        unique case (i_stat.action)
                            ACT_INSERT:                  n_state = ST_WRITE;
                            ACT_TICK:                    n_state = ST_IDLE;
                            ACT_QUERY_IP, ACT_QUERY_MAC: n_state = ST_DONE;
                        endcase
                    end
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: sv/arpc_dp.sv
// Datapath: config registers, entry tables, scan pipeline, search and output register.
module arpc_dp
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [IFACE_W-1:0]    i_iface_in,
    input  logic [IP_W-1:0]       i_ip_in,
    input  logic [MAC_W-1:0]      i_mac_in,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_found,
    output logic [IFACE_W-1:0]    o_iface_out,
    output logic [MAC_W-1:0]      o_mac_out,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0] LAST_CNT = (AW + 1)'(TABLE_ENTRIES);

    // configuration
    logic [IP_W-1:0]   r_bcast_addr;
    logic [IP_W-1:0]   r_subnet_addr;
    logic [IP_W-1:0]   r_subnet_mask;
    logic [IP_W-1:0]   r_def_router;
    logic [LIFE_W-1:0] r_lifetime;

    // current item
    t_action           r_action;
    logic [IFACE_W-1:0] r_iface;
    logic [IP_W-1:0]   r_ip;
    logic [MAC_W-1:0]  r_mac;
    logic              r_bcast;

    // scan pipeline
    logic [AW:0]       r_cnt;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;

    // search results
    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic [IFACE_W-1:0] r_hit_iface;
    logic [MAC_W-1:0]  r_hit_mac;
    logic [AW-1:0]     r_best_idx;
    logic [LIFE_W-1:0] r_best_life;

    // output register
    logic              r_out_valid;
    logic              r_found;
    logic [IFACE_W-1:0] r_iface_out;
    logic [MAC_W-1:0]  r_mac_out;

    logic [LIFE_W-1:0]  life_rdata;
    logic [ENTRY_W-1:0] entry_rdata;
    logic [IFACE_W-1:0] d_iface;
    logic [IP_W-1:0]    d_ip;
    logic [MAC_W-1:0]   d_mac;
    logic [LIFE_W-1:0]  eff_life;
    logic               live;
    logic               key_eq;
    logic               tick_dec;
    logic [AW-1:0]      slot;
    logic               issue;
    logic               in_bcast;
    logic               off_subnet;
    logic [IP_W-1:0]    key_ip;
    logic               life_we;
    logic [AW-1:0]      life_waddr;
    logic [LIFE_W-1:0]  life_wdata;

    assign {d_iface, d_ip, d_mac} = entry_rdata;

    // an entry never written reads as lifetime zero
    assign eff_life = r_valid[r_rd_idx] ? life_rdata : '0;
    assign live     = (eff_life != '0);
    assign key_eq   = (r_action == ACT_QUERY_MAC) ? (d_mac == r_mac) : (d_ip == r_ip);
    assign tick_dec = (r_action == ACT_TICK) && r_rd_vld && live;
    assign slot     = r_hit ? r_hit_idx : r_best_idx;
    assign issue    = i_cmd.scan && (r_cnt != LAST_CNT);

    assign in_bcast   = (i_ip_in == r_bcast_addr) || (i_ip_in == BCAST_IP);
    assign off_subnet = ((i_ip_in & r_subnet_mask) != (r_subnet_addr & r_subnet_mask));
    assign key_ip     = (t_action'(i_action) == ACT_QUERY_IP && off_subnet) ?
                        r_def_router : i_ip_in;

    assign life_we    = i_cmd.write || tick_dec;
    assign life_waddr = i_cmd.write ? slot : r_rd_idx;
    assign life_wdata = i_cmd.write ? r_lifetime : (eff_life - LIFE_W'(1));

    arpc_ram #(
        .WIDTH (LIFE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_life_ram (
        .i_clk   (i_clk),
        .i_we    (life_we),
        .i_waddr (life_waddr),
        .i_wdata (life_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (life_rdata)
    );

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (slot),
        .i_wdata ({r_iface, r_ip, r_mac}),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (entry_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcast_addr  <= BCAST_IP;
            r_subnet_addr <= '0;
            r_subnet_mask <= '0;
            r_def_router  <= '0;
            r_lifetime    <= DEFAULT_LIFETIME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BCAST_ADDR:  r_bcast_addr  <= i_cfg_data[IP_W-1:0];
                CFG_SUBNET_ADDR: r_subnet_addr <= i_cfg_data[IP_W-1:0];
                CFG_SUBNET_MASK: r_subnet_mask <= i_cfg_data[IP_W-1:0];
                CFG_DEF_ROUTER:  r_def_router  <= i_cfg_data[IP_W-1:0];
                CFG_LIFETIME:    r_lifetime    <= i_cfg_data[LIFE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_iface  <= i_iface_in;
            r_ip     <= key_ip;
            r_mac    <= i_mac_in;
            r_bcast  <= in_bcast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end else if (issue) begin
                r_cnt <= r_cnt + (AW + 1)'(1);
            end
            if (r_rd_vld && live && key_eq && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.write) begin
                r_valid[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx <= r_cnt[AW-1:0];
        end
        if (i_cmd.load) begin
            r_best_life <= '1;
        end else if (r_rd_vld) begin
            // <= keeps the highest index among equal lifetimes
            if (eff_life <= r_best_life) begin
                r_best_idx  <= r_rd_idx;
                r_best_life <= eff_life;
            end
            if (live && key_eq && !r_hit) begin
                r_hit_idx   <= r_rd_idx;
                r_hit_iface <= d_iface;
                r_hit_mac   <= d_mac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_action == ACT_QUERY_IP && r_bcast) begin
                r_found     <= 1'b1;
                r_iface_out <= BCAST_IFACE;
                r_mac_out   <= BCAST_MAC;
            end else begin
                r_found     <= r_hit;
                r_iface_out <= r_hit ? r_hit_iface : '0;
                r_mac_out   <= (r_hit && r_action == ACT_QUERY_IP) ? r_hit_mac : '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_iface_out = r_iface_out;
    assign o_mac_out   = r_mac_out;

    assign o_stat.action    = r_action;
    assign o_stat.bcast     = r_bcast;
    assign o_stat.scan_done = (r_cnt == LAST_CNT) && !r_rd_vld;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

endmodule

FILE: sv/arp_cache_with_aging.sv
// ARP cache top level: IPv4-to-MAC table with per-entry lifetimes.
// Every action except a broadcast query walks the table once, one entry per cycle.
// Only one item is in flight: the input is stalled from acceptance until the item finishes.
// Results sit in an output register; a new item is taken while one waits there.
// Synchronous active-low reset empties the table (valid bits) and restores config defaults.
module arp_cache_with_aging
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [IFACE_W-1:0]    i_iface_in,
    input  logic [IP_W-1:0]       i_ip_in,
    input  logic [MAC_W-1:0]      i_mac_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output logic [IFACE_W-1:0]    o_iface_out,
    output logic [MAC_W-1:0]      o_mac_out
);

    t_cmd  cmd;
    t_stat stat;

    // config writes must only arrive while idle; the user must ensure it, the block itself does not enforce it
    assign o_cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    arpc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_action    (i_action),
        .i_iface_in  (i_iface_in),
        .i_ip_in     (i_ip_in),
        .i_mac_in    (i_mac_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_iface_out (o_iface_out),
        .o_mac_out   (o_mac_out),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

FILE: sv/arpc_chk.sv
// Port-level checker for the ARP cache, bound to the top level.
module arpc_chk
    import arpc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_found,
    input logic [IFACE_W-1:0]    o_iface_out,
    input logic [MAC_W-1:0]      o_mac_out
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found)
            && $stable(o_iface_out) && $stable(o_mac_out))
        else $error("result beat changed while stalled");

    // one item at a time: the cycle after an accepted beat the input is stalled
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while busy");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_iface_out == '0 && o_mac_out == '0)
        else $error("miss with nonzero payload");

    // a MAC is only reported for a resolved query
    a_mac_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mac_out != '0 |-> o_found)
        else $error("MAC reported without a hit");

endmodule

bind arp_cache_with_aging arpc_chk u_chk (.*);

FILE: verif/arp_cache_with_aging_tb.sv
// Self-checking testbench for the ARP cache with entry aging: directed table, then random phases.
module arp_cache_with_aging_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import arpc_pkg::*;

    localparam int N_ENTRIES      = TABLE_ENTRIES_DEF;
    localparam int CLK_PERIOD     = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = N_ENTRIES + 40;
    localparam int PARK_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 5;
    localparam int BEATS_PER_PH   = 110;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic               found;
        logic [IFACE_W-1:0] iface;
        logic [MAC_W-1:0]   mac;
    } t_answer;

    localparam t_answer ANS_MISS  = '0;
    localparam t_answer ANS_BCAST = {1'b1, BCAST_IFACE, BCAST_MAC};

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_action               act;
        logic [IFACE_W-1:0]    iface;
        logic [IP_W-1:0]       ip;
        logic [MAC_W-1:0]      mac;
        bit                    typed;
        t_answer               ans;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [ACT_W-1:0]      i_action;
    logic [IFACE_W-1:0]    i_iface_in;
    logic [IP_W-1:0]       i_ip_in;
    logic [MAC_W-1:0]      i_mac_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_found;
    logic [IFACE_W-1:0]    o_iface_out;
    logic [MAC_W-1:0]      o_mac_out;

    // typed expectation travelling with the beat on the input channel
    bit      cur_typed;
    t_answer cur_ans;

    // cache mirror
    logic [LIFE_W-1:0]  ttl_tab   [N_ENTRIES];
    logic [IFACE_W-1:0] iface_tab [N_ENTRIES];
    logic [IP_W-1:0]    ip_tab    [N_ENTRIES];
    logic [MAC_W-1:0]   mac_tab   [N_ENTRIES];
    logic [IP_W-1:0]    cfg_bcast  = BCAST_IP;
    logic [IP_W-1:0]    cfg_subnet = '0;
    logic [IP_W-1:0]    cfg_mask   = '0;
    logic [IP_W-1:0]    cfg_router = '0;
    logic [LIFE_W-1:0]  cfg_life   = DEFAULT_LIFETIME;

    t_answer answers_due [$];
    t_row    plan [$];

    int  err_cnt    = 0;
    int  n_beats    = 0;
    int  n_results  = 0;
    int  n_resolved = 0;
    int  n_regs     = 0;
    int  n_settings = 0;
    int  quiet      = 0;
    bit  park_sink  = 1'b0;

    arp_cache_with_aging #(
        .TABLE_ENTRIES (N_ENTRIES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_iface_in  (i_iface_in),
        .i_ip_in     (i_ip_in),
        .i_mac_in    (i_mac_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_iface_out (o_iface_out),
        .o_mac_out   (o_mac_out)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        foreach (ttl_tab[k]) begin
            ttl_tab[k]   = '0;
            iface_tab[k] = '0;
            ip_tab[k]    = '0;
            mac_tab[k]   = '0;
        end
    end

    // live entry with this IP if any, else the lowest lifetime, last index on ties
    function automatic int victim_slot(logic [IP_W-1:0] ip);
        int best;
        best = 0;
        for (int k = 0; k < N_ENTRIES; k++) begin
            if (ttl_tab[k] != 0 && ip_tab[k] == ip)
                return k;
            if (k == 0 || ttl_tab[k] <= ttl_tab[best])
                best = k;
        end
        return best;
    endfunction

    // updates the mirror; returns 1 when the action produces an answer
    function automatic bit resolve_beat(t_action act, logic [IFACE_W-1:0] iface,
                                        logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                        output t_answer ans);
        int              slot;
        logic [IP_W-1:0] addr;
        ans  = ANS_MISS;
        addr = ip;
        case (act)
            ACT_INSERT: begin
                slot            = victim_slot(ip);
                ttl_tab[slot]   = cfg_life;
                iface_tab[slot] = iface;
                ip_tab[slot]    = ip;
                mac_tab[slot]   = mac;
                return 1'b0;
            end
            ACT_TICK: begin
                foreach (ttl_tab[k])
                    if (ttl_tab[k] != 0)
                        ttl_tab[k] = ttl_tab[k] - 1'b1;
                return 1'b0;
            end
            ACT_QUERY_IP: begin
                if (ip == cfg_bcast || ip == BCAST_IP) begin
                    ans = ANS_BCAST;
                end else begin
                    if ((ip & cfg_mask) != (cfg_subnet & cfg_mask))
                        addr = cfg_router;
                    slot = victim_slot(addr);
                    if (ttl_tab[slot] != 0 && ip_tab[slot] == addr)
                        ans = {1'b1, iface_tab[slot], mac_tab[slot]};
                end
                return 1'b1;
            end
            default: begin
                for (int k = 0; k < N_ENTRIES; k++) begin
                    if (!ans.found && ttl_tab[k] != 0 && mac_tab[k] == mac) begin
                        ans.found = 1'b1;
                        ans.iface = iface_tab[k];
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(string what, logic [MAC_W-1:0] want,
                                        logic [MAC_W-1:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // scoreboard, config mirror and watchdog, all sampled at the rising edge
    always @(posedge i_clk) begin : scoreboard
        t_answer got;
        t_answer want;
        t_answer pred;
        bit      fired;
        fired = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                fired = 1'b1;
                got   = {o_found, o_iface_out, o_mac_out};
                n_results++;
                if (got.found)
                    n_resolved++;
                if (answers_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected answer, expected none, got %0h", $time, got);
                end else begin
                    want = answers_due.pop_front();
                    check_field("found", MAC_W'(want.found), MAC_W'(got.found));
                    check_field("iface_out", MAC_W'(want.iface), MAC_W'(got.iface));
                    check_field("mac_out", want.mac, got.mac);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                fired = 1'b1;
                n_beats++;
                if (resolve_beat(t_action'(i_action), i_iface_in, i_ip_in, i_mac_in, pred))
                    answers_due.push_back(cur_typed ? cur_ans : pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                fired = 1'b1;
                n_regs++;
                case (i_cfg_index)
                    CFG_BCAST_ADDR:  cfg_bcast  = i_cfg_data;
                    CFG_SUBNET_ADDR: cfg_subnet = i_cfg_data;
                    CFG_SUBNET_MASK: cfg_mask   = i_cfg_data;
                    CFG_DEF_ROUTER:  cfg_router = i_cfg_data;
                    CFG_LIFETIME:    cfg_life   = i_cfg_data[LIFE_W-1:0];
                    default: ;
                endcase
            end
            quiet = fired ? 0 : quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result sink: random stalls, free-running stretches, and one long park on request
    initial begin : sink
        int pick;
        int span;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (park_sink) begin
                park_sink   = 1'b0;
                i_out_stall = 1'b1;
                repeat (PARK_CYCLES) @(negedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    i_out_stall = 1'b0;
                    span        = $urandom_range(1, 100);
                end else if (pick < 90) begin
                    i_out_stall = 1'b1;
                    span        = $urandom_range(1, 4);
                end else begin
                    i_out_stall = 1'b1;
                    span        = $urandom_range(20, 150);
                end
                repeat (span - 1) @(negedge i_clk);
            end
        end
    end

    function automatic t_row mk_beat(t_action act, logic [IFACE_W-1:0] iface,
                                     logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                     bit typed = 1'b0, t_answer ans = ANS_MISS);
        t_row row;
        row.kind    = ROW_BEAT;
        row.act     = act;
        row.iface   = iface;
        row.ip      = ip;
        row.mac     = mac;
        row.typed   = typed;
        row.ans     = ans;
        row.reg_idx = '0;
        row.reg_val = '0;
        return row;
    endfunction

    function automatic t_row mk_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_row row;
        row         = mk_beat(ACT_TICK, '0, '0, '0);
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // hold the input side until every answer is back and the block has settled
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_row(t_row row, int gap);
        if (row.kind == ROW_REG) begin
            wait_drained();
            @(negedge i_clk);
            i_cfg_valid = 1'b1;
            i_cfg_index = row.reg_idx;
            i_cfg_data  = row.reg_val;
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
            i_cfg_valid = 1'b0;
        end else begin
            @(negedge i_clk);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid = 1'b1;
            i_action   = row.act;
            i_iface_in = row.iface;
            i_ip_in    = row.ip;
            i_mac_in   = row.mac;
            cur_typed  = row.typed;
            cur_ans    = row.ans;
            do @(posedge i_clk); while (o_in_stall);
        end
    endtask

    initial begin : stimulus
        logic [IP_W-1:0]   ip_pool [$];
        logic [MAC_W-1:0]  mac_pool [$];
        logic [IP_W-1:0]   bcast_v;
        logic [IP_W-1:0]   subnet_v;
        logic [IP_W-1:0]   mask_v;
        logic [IP_W-1:0]   router_v;
        logic [LIFE_W-1:0] life_v;
        logic [IP_W-1:0]   ip_v;
        logic [MAC_W-1:0]  mac_v;
        t_action           act_v;
        bit                steady;
        int                n_ip;
        int                n_mac;
        int                pick;

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_action    = ACT_TICK;
        i_iface_in  = '0;
        i_ip_in     = '0;
        i_mac_in    = '0;
        cur_typed   = 1'b0;
        cur_ans     = ANS_MISS;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, default settings: empty table, then extremes and refresh
        n_settings++;
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h5A, 32'h0A00_0001, rand_mac(), 1'b1, ANS_MISS));
        plan.push_back(mk_beat(ACT_QUERY_MAC, 8'hA5, 32'($urandom), '0, 1'b1, ANS_MISS));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, BCAST_IP, rand_mac(), 1'b1, ANS_BCAST));
        plan.push_back(mk_beat(ACT_INSERT, 8'h00, 32'h0000_0000, 48'h0));
        plan.push_back(mk_beat(ACT_INSERT, 8'hFF, BCAST_IP, BCAST_MAC));
        plan.push_back(mk_beat(ACT_INSERT, 8'h12, 32'h0A00_0001, 48'h0000_1122_3344));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'hFF, 32'h0000_0000, rand_mac()));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, 32'h0A00_0001, rand_mac()));
        plan.push_back(mk_beat(ACT_QUERY_MAC, 8'h00, 32'($urandom), BCAST_MAC));
        plan.push_back(mk_beat(ACT_QUERY_MAC, 8'h00, 32'($urandom), 48'h0000_1122_3344));
        plan.push_back(mk_beat(ACT_INSERT, 8'h34, 32'h0A00_0001, 48'hA5A5_5A5A_A5A5));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, 32'h0A00_0001, rand_mac()));
        plan.push_back(mk_beat(ACT_QUERY_MAC, 8'h00, 32'h0A00_0001, 48'h0000_1122_3344));
        plan.push_back(mk_beat(ACT_TICK, 8'($urandom), 32'($urandom), rand_mac()));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'($urandom), BCAST_IP, rand_mac(), 1'b1,
                               ANS_BCAST));
        plan.push_back(mk_beat(ACT_QUERY_MAC, 8'h00, 32'h0, 48'h0000_0000_0001));

        // subnet setup: local broadcast, off-subnet via router, one-tick lifetime
        plan.push_back(mk_reg(CFG_BCAST_ADDR, 32'h0A00_00FF));
        plan.push_back(mk_reg(CFG_SUBNET_ADDR, 32'h0A00_0000));
        plan.push_back(mk_reg(CFG_SUBNET_MASK, 32'hFFFF_FF00));
        plan.push_back(mk_reg(CFG_DEF_ROUTER, 32'h0A00_0001));
        plan.push_back(mk_reg(CFG_LIFETIME, 32'h0000_0001));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, 32'h0A00_00FF, rand_mac(), 1'b1, ANS_BCAST));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, 32'hC0A8_0001, rand_mac()));
        plan.push_back(mk_beat(ACT_INSERT, 8'h77, 32'h0A00_0002, 48'h0200_0000_0002));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, 32'h0A00_0002, rand_mac()));
        plan.push_back(mk_beat(ACT_TICK, 8'h00, 32'h0, 48'h0));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, 32'h0A00_0002, rand_mac()));

        // zero lifetime from a word whose upper bits are set; spare indexes are ignored
        plan.push_back(mk_reg(CFG_LIFETIME, 32'hFFFF_FC00));
        for (int s = int'(CFG_LIFETIME) + 1; s < 2 ** CFG_IDX_W; s++)
            plan.push_back(mk_reg(CFG_IDX_W'(s), $urandom));
        plan.push_back(mk_beat(ACT_INSERT, 8'h99, 32'h0A00_0003, 48'h0300_0000_0003));
        plan.push_back(mk_beat(ACT_QUERY_IP, 8'h00, 32'h0A00_0003, rand_mac()));
        plan.push_back(mk_beat(ACT_QUERY_MAC, 8'h00, 32'h0, 48'h0300_0000_0003));
        n_settings++;

        foreach (plan[i])
            run_row(plan[i], pick_gap());

        // random phases; the table carries over so later phases overflow and age it
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    bcast_v  = '0;
                    subnet_v = '0;
                    mask_v   = '0;
                    router_v = '0;
                    life_v   = '1;
                end
                1: begin
                    subnet_v = {8'h0A, 16'($urandom), 8'h00};
                    mask_v   = 32'hFFFF_FF00;
                    bcast_v  = subnet_v | 32'h0000_00FF;
                    router_v = subnet_v | 32'($urandom_range(1, 254));
                    life_v   = 10'd5;
                end
                2: begin
                    subnet_v = $urandom;
                    mask_v   = '1;
                    bcast_v  = $urandom;
                    router_v = $urandom;
                    life_v   = LIFE_W'($urandom_range(1, 30));
                end
                3: begin
                    subnet_v = $urandom;
                    mask_v   = $urandom;
                    bcast_v  = BCAST_IP;
                    router_v = $urandom;
                    life_v   = LIFE_W'($urandom_range(1, 1023));
                end
                default: begin
                    subnet_v = $urandom;
                    mask_v   = 32'hFFFF_0000;
                    bcast_v  = $urandom;
                    router_v = $urandom;
                    life_v   = LIFE_W'($urandom_range(0, 3));
                end
            endcase
            run_row(mk_reg(CFG_BCAST_ADDR, bcast_v), 0);
            run_row(mk_reg(CFG_SUBNET_ADDR, subnet_v), 0);
            run_row(mk_reg(CFG_SUBNET_MASK, mask_v), 0);
            run_row(mk_reg(CFG_DEF_ROUTER, router_v), 0);
            run_row(mk_reg(CFG_LIFETIME, {22'($urandom), life_v}), 0);
            if (ph % 2 == 1)
                run_row(mk_reg(CFG_LIFETIME + CFG_IDX_W'($urandom_range(1, 3)), $urandom), 0);
            n_settings++;

            ip_pool.delete();
            mac_pool.delete();
            n_ip  = (ph == N_PHASES - 1) ? 120 : $urandom_range(6, 70);
            n_mac = $urandom_range(2, 40);
            for (int k = 0; k < n_ip; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    ip_pool.push_back((subnet_v & mask_v) | (32'($urandom) & ~mask_v));
                else if (pick < 80)
                    ip_pool.push_back($urandom);
                else
                    ip_pool.push_back(router_v);
            end
            for (int k = 0; k < n_mac; k++)
                mac_pool.push_back(rand_mac());

            // phase 2 parks the sink while the source keeps offering; phase 3 has no gaps
            steady = (ph == 2 || ph == 3);
            if (ph == 2)
                park_sink = 1'b1;

            for (int b = 0; b < BEATS_PER_PH; b++) begin
                pick  = $urandom_range(0, 99);
                ip_v  = ip_pool[$urandom_range(0, n_ip - 1)];
                mac_v = ($urandom_range(0, 9) == 0) ? rand_mac()
                                                    : mac_pool[$urandom_range(0, n_mac - 1)];
                if (pick < 35) begin
                    act_v = ACT_INSERT;
                end else if (pick < 65) begin
                    act_v = ACT_QUERY_IP;
                    case ($urandom_range(0, 19))
                        0:       ip_v = bcast_v;
                        1:       ip_v = BCAST_IP;
                        2:       ip_v = $urandom;
                        default: ;
                    endcase
                end else if (pick < 85) begin
                    act_v = ACT_QUERY_MAC;
                end else begin
                    act_v = ACT_TICK;
                end
                run_row(mk_beat(act_v, 8'($urandom), ip_v, mac_v), steady ? 0 : pick_gap());
            end
        end

        wait_drained();
        $display("Ran %0d items over %0d settings with %0d register writes; %0d answers, %0d hits.",
                 n_beats, n_settings, n_regs, n_results, n_resolved);
        $display("Covered broadcast, off-subnet, refresh, ageing, replacement and back-pressure.");
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/arpc_ctrl.sv
sv/arpc_dp.sv
sv/arp_cache_with_aging.sv
sv/arpc_chk.sv
verif/arp_cache_with_aging_tb.sv
